FILE: src/max_flow_bfs_augmenting_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the max-flow block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MAX_FLOW_BFS_AUGMENTING_ASSERT_SVH
`define MAX_FLOW_BFS_AUGMENTING_ASSERT_SVH

// same-cycle implication
`define MFBFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFBFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mfbfs_pkg.sv
// ---------------------------------------------------------------------------
// mfbfs_pkg
// Shared types and codes of the max-flow block.
// ---------------------------------------------------------------------------
package mfbfs_pkg;

	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;
	localparam int CAP_W   = 31;
	localparam int FLOW_W  = 37;
	localparam int PADDR_W = 4;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	// unused code: dropped without a result
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [1:0] REG_SOURCE = 2'd0;
	localparam logic [1:0] REG_SINK   = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0]  source_node;
		logic [NODE_W-1:0]  sink_node;
		logic [COUNT_W-1:0] node_count;
	} cfg_t;

endpackage

FILE: src/mfbfs_ram.sv
// ---------------------------------------------------------------------------
// mfbfs_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mfbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/mfbfs_cfg.sv
// ---------------------------------------------------------------------------
// mfbfs_cfg
// APB register file: source, sink and node count.
// ---------------------------------------------------------------------------
module mfbfs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfbfs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output mfbfs_pkg::cfg_t              cfg
);
	import mfbfs_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_node <= NODE_W'(0);
			cfg_q.sink_node   <= NODE_W'(1);
			cfg_q.node_count  <= COUNT_W'(64);
		end else if (wr) begin
			case (paddr[3:2])
				REG_SOURCE: cfg_q.source_node <= pwdata[NODE_W-1:0];
				REG_SINK:   cfg_q.sink_node   <= pwdata[NODE_W-1:0];
				REG_COUNT:  cfg_q.node_count  <= pwdata[COUNT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SOURCE: prdata = 32'(cfg_q.source_node);
			REG_SINK:   prdata = 32'(cfg_q.sink_node);
			REG_COUNT:  prdata = 32'(cfg_q.node_count);
			default:    prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/max_flow_bfs_augmenting.sv
// ---------------------------------------------------------------------------
// max_flow_bfs_augmenting
// Edmonds-Karp maximum flow over a residual capacity RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the command
//   (write edge, run, clear); s_tdata carries from_node, to_node, capacity.
//   An edge write goes to the RAM as it is accepted, so writes stream one per cycle while idle.
//   A clear sweeps all MAX_NODES*MAX_NODES entries of the capacity RAM one
//   entry a cycle with s_tready low. The same sweep runs straight after reset,
//   so the block accepts nothing until that sweep ends.
//   A run holds s_tready low while it searches. BFS scans a neighbour by a RAM
//   read then a check, and pops by a pop then a wait. A path found is walked
//   for its bottleneck (pred, cap read, compare per hop), then updated (pred,
//   fwd read, fwd write, rev write per hop), all on the one residual RAM port.
//   The run ends with one word of max_flow on m_tvalid/m_tready, held in an
//   output register; edge writes keep flowing while that word waits, and a
//   following run parks at its end until the register is free.
//   Source, sink and node count are to be set over APB while the block is idle; not enforced.
// ---------------------------------------------------------------------------
module max_flow_bfs_augmenting #(
	parameter int MAX_NODES     = 64,
	parameter int CAPACITY_BITS = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,  // from_node[5:0], to_node[11:6], capacity[42:12]
	input  logic [1:0]                    s_tuser,  // command[1:0]
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // max_flow[36:0]
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mfbfs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mfbfs_pkg::*;

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CW    = NW + 1;
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	// a residual may grow to the sum of both directions
	localparam int RW    = CAPACITY_BITS + 1;
	localparam logic [32:0] CAP_MASK = (33'd1 << CAPACITY_BITS) - 33'd1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RUN   = 4'd2;
	localparam logic [3:0] ST_BFS   = 4'd3;
	localparam logic [3:0] ST_POP   = 4'd4;
	localparam logic [3:0] ST_POPW  = 4'd5;
	localparam logic [3:0] ST_RD    = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_BRDP  = 4'd8;
	localparam logic [3:0] ST_BRDC  = 4'd9;
	localparam logic [3:0] ST_BCMP  = 4'd10;
	localparam logic [3:0] ST_ARDP  = 4'd11;
	localparam logic [3:0] ST_ARDF  = 4'd12;
	localparam logic [3:0] ST_AWRF  = 4'd13;
	localparam logic [3:0] ST_AWRR  = 4'd14;
	localparam logic [3:0] ST_DONE  = 4'd15;

	function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] u, input logic [NW-1:0] v);
		cell_addr = AW'(AW'(u) * AW'(MAX_NODES)) + AW'(v);
	endfunction

	cfg_t cfg;

	mfbfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input fields
	logic [1:0]        in_cmd;
	logic [NODE_W-1:0] in_from;
	logic [NODE_W-1:0] in_to;
	logic [CAP_W-1:0]  in_cap;
	logic              in_acc;

	assign in_cmd  = s_tuser;
	assign in_from = s_tdata[5:0];
	assign in_to   = s_tdata[11:6];
	assign in_cap  = s_tdata[42:12];

	logic [3:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [MAX_NODES-1:0] vis_q;
	logic [CW-1:0]     head_q, tail_q, v_q;
	logic [NW-1:0]     u_q, w_q;
	logic [RW-1:0]     bn_q;
	logic [FLOW_W-1:0] flow_q;
	logic              ovalid_q;
	logic [FLOW_W-1:0] odata_q;

	// RAM ports
	logic          res_we, pr_we, qu_we;
	logic [AW-1:0] res_waddr, res_raddr;
	logic [RW-1:0] res_wdata, res_rdata;
	logic [NW-1:0] pr_waddr, pr_wdata, pr_raddr, pr_rdata;
	logic [NW-1:0] qu_waddr, qu_wdata, qu_raddr, qu_rdata;

	mfbfs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(res_raddr), .rdata(res_rdata)
	);
	mfbfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pred (
		.clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
		.raddr(pr_raddr), .rdata(pr_rdata)
	);
	mfbfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata),
		.raddr(qu_raddr), .rdata(qu_rdata)
	);

	// run bounds
	logic [CW-1:0] n_c;
	logic [NW-1:0] src_n, dst_n;
	logic          run_bad;
	logic          edge_ok;
	logic          take;
	logic [RW-1:0] bmin;
	logic [CW-1:0] v_nx;

	assign n_c = (int'(cfg.node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cfg.node_count);
	assign src_n = NW'(cfg.source_node);
	assign dst_n = NW'(cfg.sink_node);
	assign run_bad = (cfg.source_node == cfg.sink_node) ||
		(int'(cfg.source_node) >= int'(n_c)) || (int'(cfg.sink_node) >= int'(n_c));
	assign edge_ok = (int'(in_from) < MAX_NODES) && (int'(in_to) < MAX_NODES);
	assign take = !vis_q[v_q[NW-1:0]] && (res_rdata != '0);
	assign bmin = (res_rdata < bn_q) ? res_rdata : bn_q;
	assign v_nx = v_q + CW'(1);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = 40'(odata_q);

	always_comb begin
		res_we    = 1'b0;
		res_waddr = cell_addr(NW'(in_from), NW'(in_to));
		res_wdata = RW'({2'b00, in_cap} & CAP_MASK);
		res_raddr = cell_addr(u_q, v_q[NW-1:0]);
		pr_we     = 1'b0;
		pr_waddr  = v_q[NW-1:0];
		pr_wdata  = u_q;
		pr_raddr  = w_q;
		qu_we     = 1'b0;
		qu_waddr  = tail_q[NW-1:0];
		qu_wdata  = v_q[NW-1:0];
		qu_raddr  = head_q[NW-1:0];
		case (state_q)
			ST_CLEAR: begin
				res_we    = 1'b1;
				res_waddr = clr_q;
				res_wdata = '0;
			end
			ST_IDLE: begin
				res_we = in_acc && (in_cmd == CMD_WRITE) && edge_ok;
			end
			ST_BFS: begin
				// source is its own predecessor and the first queue entry
				pr_we    = 1'b1;
				pr_waddr = src_n;
				pr_wdata = src_n;
				qu_we    = 1'b1;
				qu_waddr = '0;
				qu_wdata = src_n;
			end
			ST_CHK: begin
				pr_we = take;
				qu_we = take && (v_q[NW-1:0] != dst_n) && (tail_q < CW'(MAX_NODES));
			end
			ST_BRDC, ST_ARDF: begin
				res_raddr = cell_addr(pr_rdata, w_q);
			end
			ST_AWRF: begin
				res_we    = 1'b1;
				res_waddr = cell_addr(u_q, w_q);
				res_wdata = res_rdata - bn_q;
				res_raddr = cell_addr(w_q, u_q);
			end
			ST_AWRR: begin
				res_we    = 1'b1;
				res_waddr = cell_addr(w_q, u_q);
				res_wdata = res_rdata + bn_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			vis_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			v_q      <= '0;
			u_q      <= '0;
			w_q      <= '0;
			bn_q     <= '0;
			flow_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			// drop the word once taken; a finishing run reloads it instead
			if (ovalid_q && m_tready && (state_q != ST_DONE)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							CMD_RUN: state_q <= ST_RUN;
							CMD_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					flow_q  <= '0;
					state_q <= run_bad ? ST_DONE : ST_BFS;
				end
				ST_BFS: begin
					vis_q          <= MAX_NODES'(1) << src_n;
					head_q         <= '0;
					tail_q         <= CW'(1);
					state_q        <= ST_POP;
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q  <= head_q + CW'(1);
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					u_q     <= qu_rdata;
					v_q     <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (take) begin
						vis_q[v_q[NW-1:0]] <= 1'b1;
					end
					if (take && (v_q[NW-1:0] == dst_n)) begin
						// sink reached: walk the path for its bottleneck
						w_q     <= dst_n;
						bn_q    <= '1;
						state_q <= ST_BRDP;
					end else begin
						if (take && (tail_q < CW'(MAX_NODES))) begin
							tail_q <= tail_q + CW'(1);
						end
						v_q     <= v_nx;
						state_q <= (v_nx == n_c) ? ST_POP : ST_RD;
					end
				end
				ST_BRDP: begin
					state_q <= ST_BRDC;
				end
				ST_BRDC: begin
					u_q     <= pr_rdata;
					state_q <= ST_BCMP;
				end
				ST_BCMP: begin
					bn_q <= bmin;
					if (u_q == src_n) begin
						flow_q  <= flow_q + FLOW_W'(bmin);
						w_q     <= dst_n;
						state_q <= ST_ARDP;
					end else begin
						w_q     <= u_q;
						state_q <= ST_BRDP;
					end
				end
				ST_ARDP: begin
					state_q <= ST_ARDF;
				end
				ST_ARDF: begin
					u_q     <= pr_rdata;
					state_q <= ST_AWRF;
				end
				ST_AWRF: begin
					state_q <= ST_AWRR;
				end
				ST_AWRR: begin
					// hop done: step back, or search again from the source
					w_q     <= u_q;
					state_q <= (u_q == src_n) ? ST_BFS : ST_ARDP;
				end
				ST_DONE: begin
					if (!ovalid_q || m_tready) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!ovalid_q || m_tready)) begin
			odata_q <= flow_q;
		end
	end

`include "max_flow_bfs_augmenting_assert.svh"

	`MFBFS_ASSERT_NOW(a_src_visited, state_q == ST_CHK, vis_q[src_n], "source not marked visited during scan")
	`MFBFS_ASSERT_NOW(a_queue_order, state_q == ST_POP || state_q == ST_CHK, head_q <= tail_q, "queue head passed tail")
	`MFBFS_ASSERT_NOW(a_no_underflow, state_q == ST_AWRF, res_rdata >= bn_q, "bottleneck exceeds forward residual")
	`MFBFS_ASSERT_NEXT(a_bn_nonzero, state_q == ST_BCMP && u_q == src_n, bn_q != '0, "zero bottleneck on augmenting path")

endmodule
